/* src/rtid_pkg.sv */
// Shared constants and control/status types for the signed integer to radix text block.
package rtid_pkg;

  // Field and storage widths
  localparam int VAL_W      = 32;               // input value
  localparam int MAG_W      = 32;               // magnitude, enough for 2^31
  localparam int CH_W       = 8;                // one character
  localparam int LEN_W      = 5;                // base_length register
  localparam int CFG_W      = 64;               // widest configuration register
  localparam int IDX_W      = 2;                // configuration register index
  localparam int MAX_BASE   = 16;               // largest radix
  localparam int DIG_W      = 4;                // one digit value, below MAX_BASE
  localparam int ALPHA_W    = 2 * CFG_W;        // both alphabet registers
  localparam int MAX_DIGITS = MAG_W;            // base 2 worst case
  localparam int DCNT_W     = $clog2(MAX_DIGITS + 1);
  localparam int SP_W       = $clog2(MAX_DIGITS);
  localparam int NIBS       = MAG_W / DIG_W;    // quotient nibbles per pass
  localparam int NIB_CNT_W  = $clog2(NIBS);

  // Configuration register indexes
  localparam logic [IDX_W-1:0] REG_DIGITS_LOW  = 2'd0;
  localparam logic [IDX_W-1:0] REG_DIGITS_HIGH = 2'd1;
  localparam logic [IDX_W-1:0] REG_BASE_LENGTH = 2'd2;

  // Character codes
  localparam logic [CH_W-1:0] CH_MINUS  = 8'h2D;
  localparam logic [CH_W-1:0] CH_PLUS   = 8'h2B;
  localparam logic [CH_W-1:0] CH_SPACE  = 8'd32;
  localparam logic [CH_W-1:0] CH_WS_LO  = 8'd9;
  localparam logic [CH_W-1:0] CH_WS_HI  = 8'd13;
  localparam logic [CH_W-1:0] CH_NUL    = 8'd0;

  // Divider control from the sequencer
  typedef struct packed {
    logic load;   // take a new dividend
    logic run;    // process one quotient nibble
  } div_ctl_t;

  // Divider status back to the sequencer
  typedef struct packed {
    logic             done;   // a pass has finished this cycle
    logic             zero;   // quotient of that pass is zero
    logic [DIG_W-1:0] digit;  // remainder of that pass
  } div_stat_t;

endpackage

/* src/rtid_div.sv */
// Nibble-serial divider: divides the magnitude by the radix, one quotient nibble per run cycle.
module rtid_div import rtid_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  div_ctl_t         ctl,
  input  logic [MAG_W-1:0] mag,
  input  logic [LEN_W-1:0] radix,
  output div_stat_t        stat
);

  logic [MAG_W-1:0]     q_r, q_nxt;
  logic [DIG_W-1:0]     rem_r, rem_nxt;
  logic [NIB_CNT_W-1:0] cnt_r;
  logic [DIG_W-1:0]     nib, qnib;
  logic [LEN_W-1:0]     part;
  logic                 pass_end;

  // Four restoring steps on the top nibble of the shifting quotient
  always_comb begin
    nib  = q_r[MAG_W-1 -: DIG_W];
    part = {1'b0, rem_r};
    qnib = '0;
    for (int k = DIG_W - 1; k >= 0; k--) begin
      part = {part[LEN_W-2:0], nib[k]};
      if (part >= radix) begin
        part    = part - radix;
        qnib[k] = 1'b1;
      end
    end
    q_nxt   = {q_r[MAG_W-DIG_W-1:0], qnib};
    rem_nxt = part[DIG_W-1:0];
  end

  assign pass_end    = ctl.run && (cnt_r == NIB_CNT_W'(NIBS - 1));
  assign stat.done   = pass_end;
  assign stat.zero   = (q_nxt == '0);
  assign stat.digit  = rem_nxt;

  // Pass counter; wraps so the next pass starts on the new quotient
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (ctl.load) begin
      cnt_r <= '0;
    end else if (ctl.run) begin
      cnt_r <= cnt_r + 1'b1;
    end
  end

  // Quotient shift register and running remainder
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      q_r   <= mag;
      rem_r <= '0;
    end else if (ctl.run) begin
      q_r   <= q_nxt;
      rem_r <= pass_end ? '0 : rem_nxt;
    end
  end

endmodule

/* src/signed_int_to_radix_digits.sv */
// Top level: writes a signed 32-bit integer as text in a configured digit alphabet.
//
// Use: load digits_low, digits_high and base_length through the cfg_ write port
// (index 0, 1, 2) while busy is low. Pulse start with in_value while busy is low;
// the transaction is taken at that edge and busy rises on the next cycle.
// The alphabet is checked first, one byte per cycle. An invalid alphabet ends
// the transaction there with no output at all. The magnitude is then divided by
// the radix, one quotient nibble per cycle in the divider, until the quotient is
// zero. Finally the characters leave one per cycle on out_char_out with
// out_valid high: '-' for a negative value, then the digits most significant
// first, out_last on the final one. Busy falls while the final character is
// shown, so the next transaction can be taken at the edge that ends it.
// The receiver cannot stall: each character is shown for exactly one cycle.
// A synchronous reset (rst_n low) drops any transaction in flight and clears
// the configuration registers to zero, which is an invalid alphabet.
module signed_int_to_radix_digits import rtid_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  logic [VAL_W-1:0] in_value,
  output logic             out_valid,
  output logic [CH_W-1:0]  out_char_out,
  output logic             out_last,
  input  logic             cfg_we,
  input  logic [IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0] cfg_wdata
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_CHECK = 2'd1;
  localparam logic [1:0] S_DIV   = 2'd2;
  localparam logic [1:0] S_EMIT  = 2'd3;

  logic [CFG_W-1:0]  digits_low_r, digits_high_r;
  logic [LEN_W-1:0]  base_length_r;
  logic [ALPHA_W-1:0] alpha;

  logic [1:0]        state_r, state_nxt;
  logic [DIG_W-1:0]  idx_r, idx_nxt;
  logic              neg_r, neg_nxt;
  logic [DCNT_W-1:0] dcnt_r, dcnt_nxt;
  logic [DIG_W-1:0]  stack_r [MAX_DIGITS];
  logic              push;

  logic              out_valid_r, out_valid_nxt;
  logic [CH_W-1:0]   out_char_r, out_char_nxt;
  logic              out_last_r, out_last_nxt;

  logic              accept;
  logic [MAG_W-1:0]  mag;
  logic [CH_W-1:0]   cur;
  logic              len_bad, byte_bad, dup;
  logic [SP_W-1:0]   top_idx;
  logic [DIG_W-1:0]  top_dig;

  div_ctl_t          dctl;
  div_stat_t         dstat;

  assign alpha  = {digits_high_r, digits_low_r};
  assign accept = start && !busy;
  assign busy   = (state_r != S_IDLE);

  // Magnitude; the most negative value wraps to 2^31, which is correct
  assign mag = in_value[VAL_W-1] ? MAG_W'(-in_value) : MAG_W'(in_value);

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      digits_low_r  <= '0;
      digits_high_r <= '0;
      base_length_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_DIGITS_LOW:  digits_low_r  <= cfg_wdata;
        REG_DIGITS_HIGH: digits_high_r <= cfg_wdata;
        REG_BASE_LENGTH: base_length_r <= cfg_wdata[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // Check of base_length, and of byte idx_r against forbidden codes and later bytes
  always_comb begin
    cur      = alpha[idx_r*CH_W +: CH_W];
    len_bad  = (base_length_r < LEN_W'(2)) || (base_length_r > LEN_W'(MAX_BASE));
    byte_bad = (cur == CH_NUL) || (cur == CH_PLUS) || (cur == CH_MINUS) ||
               (cur == CH_SPACE) || ((cur >= CH_WS_LO) && (cur <= CH_WS_HI));
    dup      = 1'b0;
    for (int j = 0; j < MAX_BASE; j++) begin
      if ((LEN_W'(j) > {1'b0, idx_r}) && (LEN_W'(j) < base_length_r) &&
          (alpha[j*CH_W +: CH_W] == cur)) begin
        dup = 1'b1;
      end
    end
  end

  rtid_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (dctl),
    .mag   (mag),
    .radix (base_length_r),
    .stat  (dstat)
  );

  assign top_idx = SP_W'(dcnt_r - 1'b1);
  assign top_dig = stack_r[top_idx];

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    neg_nxt       = neg_r;
    dcnt_nxt      = dcnt_r;
    push          = 1'b0;
    dctl.load     = 1'b0;
    dctl.run      = 1'b0;
    out_valid_nxt = 1'b0;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          dctl.load = 1'b1;
          neg_nxt   = in_value[VAL_W-1];
          idx_nxt   = '0;
          dcnt_nxt  = '0;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (len_bad || byte_bad || dup) begin
          state_nxt = S_IDLE;
        end else if ({1'b0, idx_r} == base_length_r - 1'b1) begin
          state_nxt = S_DIV;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      S_DIV: begin
        dctl.run = 1'b1;
        if (dstat.done) begin
          push     = 1'b1;
          dcnt_nxt = dcnt_r + 1'b1;
          if (dstat.zero) begin
            state_nxt = S_EMIT;
          end
        end
      end
      S_EMIT: begin
        out_valid_nxt = 1'b1;
        if (neg_r) begin
          neg_nxt      = 1'b0;
          out_char_nxt = CH_MINUS;
          out_last_nxt = 1'b0;
        end else begin
          dcnt_nxt     = dcnt_r - 1'b1;
          out_char_nxt = alpha[top_dig*CH_W +: CH_W];
          out_last_nxt = (dcnt_r == DCNT_W'(1));
          if (dcnt_r == DCNT_W'(1)) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      idx_r       <= '0;
      neg_r       <= 1'b0;
      dcnt_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      neg_r       <= neg_nxt;
      dcnt_r      <= dcnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Digit stack and output payload
  always_ff @(posedge clk) begin
    if (push) begin
      stack_r[dcnt_r[SP_W-1:0]] <= dstat.digit;
    end
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid    = out_valid_r;
  assign out_char_out = out_char_r;
  assign out_last     = out_last_r;

  // Checks
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> busy)
    else $error("transaction taken but busy did not rise");

  a_digit_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) && dstat.done |-> (LEN_W'(dstat.digit) < base_length_r))
    else $error("divider remainder not below the radix");

  a_stack_bound: assert property (@(posedge clk) disable iff (!rst_n)
    dcnt_r <= DCNT_W'(MAX_DIGITS))
    else $error("digit stack overflow");

  a_burst: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |=> out_valid)
    else $error("gap inside a character burst");

  a_last_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last |=> !out_valid)
    else $error("character after the final one");

endmodule

/* sim/signed_int_to_radix_digits_tb.sv */
// Self-checking testbench for the signed integer to radix text converter.
module signed_int_to_radix_digits_tb;
  import rtid_pkg::*;

  localparam int QUIET_CYCLES = 24;    // idle cycles before a register write
  localparam int TAIL_CYCLES  = 320;   // longest conversion plus margin
  localparam int STALL_LIMIT  = 6000;  // cycles with no transaction at all
  localparam int RANDOM_ITEMS = 306;   // conversions in the random phase

  typedef enum logic [1:0] {ACT_CONVERT, ACT_WRITE, ACT_SETTLE} act_kind_t;

  typedef struct {
    act_kind_t        act;
    logic [VAL_W-1:0] value;
    logic [IDX_W-1:0] index;
    logic [CFG_W-1:0] data;
    int               gap_pct;
  } act_t;

  typedef struct packed {
    logic [CH_W-1:0] ch;
    logic            last;
  } text_char_t;

  logic             clk;
  logic             rst_n;
  logic             start;
  logic             busy;
  logic [VAL_W-1:0] in_value;
  logic             out_valid;
  logic [CH_W-1:0]  out_char_out;
  logic             out_last;
  logic             cfg_we;
  logic [IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_wdata;

  act_t       pending[$];
  text_char_t expected_chars[$];
  int         gap_now;
  int         quiet;
  int         stall;
  int         fails;

  // Mirror of the alphabet registers
  logic [CFG_W-1:0] alpha_lo;
  logic [CFG_W-1:0] alpha_hi;
  logic [LEN_W-1:0] radix_len;

  signed_int_to_radix_digits DUT (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_value     (in_value),
    .out_valid    (out_valid),
    .out_char_out (out_char_out),
    .out_last     (out_last),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata)
  );

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  function automatic logic [CH_W-1:0] alpha_at(int k);
    if (k < 8) return alpha_lo[8*k +: CH_W];
    return alpha_hi[8*(k-8) +: CH_W];
  endfunction

  function automatic bit forbidden_char(logic [CH_W-1:0] c);
    return c == CH_NUL || c == CH_PLUS || c == CH_MINUS || c == CH_SPACE ||
           (c >= CH_WS_LO && c <= CH_WS_HI);
  endfunction

  function automatic bit alphabet_valid();
    int n, i, j;
    n = int'(radix_len);
    if (n < 2 || n > MAX_BASE) return 0;
    for (i = 0; i < n; i++) begin
      if (forbidden_char(alpha_at(i))) return 0;
      for (j = i + 1; j < n; j++)
        if (alpha_at(j) == alpha_at(i)) return 0;
    end
    return 1;
  endfunction

  // Queue up the characters that one value is written out as
  function automatic void predict_text(logic [VAL_W-1:0] value);
    logic [VAL_W:0]  mag;
    logic [VAL_W:0]  radix;
    logic [CH_W-1:0] digits[$];
    int              k;
    if (!alphabet_valid()) return;
    radix = (VAL_W+1)'(radix_len);
    // 33-bit magnitude, so the most negative value comes out exactly
    mag = value[VAL_W-1] ? ((VAL_W+1)'(0) - {value[VAL_W-1], value}) : {1'b0, value};
    do begin
      digits.push_back(alpha_at(int'(mag % radix)));
      mag = mag / radix;
    end while (mag != 0);
    if (value[VAL_W-1]) expected_chars.push_back('{ch: CH_MINUS, last: 1'b0});
    for (k = digits.size() - 1; k >= 0; k--)
      expected_chars.push_back('{ch: digits[k], last: k == 0});
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic void add_convert(logic [VAL_W-1:0] value);
    pending.push_back('{act: ACT_CONVERT, value: value, index: REG_DIGITS_LOW,
                        data: '0, gap_pct: gap_now});
  endfunction

  function automatic void add_write(logic [IDX_W-1:0] index, logic [CFG_W-1:0] data);
    pending.push_back('{act: ACT_WRITE, value: '0, index: index, data: data,
                        gap_pct: gap_now});
  endfunction

  function automatic void add_settle();
    pending.push_back('{act: ACT_SETTLE, value: '0, index: REG_DIGITS_LOW, data: '0,
                        gap_pct: gap_now});
  endfunction

  function automatic logic [CH_W-1:0] pick_forbidden();
    case ($urandom_range(4))
      0:       return CH_NUL;
      1:       return CH_PLUS;
      2:       return CH_MINUS;
      3:       return CH_SPACE;
      default: return CH_WS_LO + CH_W'($urandom_range(CH_WS_HI - CH_WS_LO));
    endcase
  endfunction

  // Random alphabet, distinct legal bytes within the length, mostly valid
  function automatic void make_alphabet(output logic [CFG_W-1:0] lo,
                                        output logic [CFG_W-1:0] hi,
                                        output logic [LEN_W-1:0] len);
    logic [CH_W-1:0] b[16];
    logic [255:0]    used;
    logic [CH_W-1:0] c;
    int              n, i, j;
    n = $urandom_range(MAX_BASE, 2);
    used = '0;
    for (i = 0; i < 16; i++) begin
      c = CH_W'($urandom);
      if (i < n)
        while (forbidden_char(c) || used[c]) c = CH_W'($urandom);
      used[c] = 1'b1;
      b[i] = c;
    end
    case ($urandom_range(9))
      0: begin
        n = $urandom_range(1);
      end
      1: begin
        n = $urandom_range(31, MAX_BASE + 1);
      end
      2: begin
        b[$urandom_range(n - 1)] = pick_forbidden();
      end
      3: begin
        i = $urandom_range(n - 1);
        j = (i + 1 + $urandom_range(n - 2)) % n;
        b[i] = b[j];
      end
      default: ;
    endcase
    for (i = 0; i < 8; i++) begin
      lo[8*i +: CH_W] = b[i];
      hi[8*i +: CH_W] = b[i+8];
    end
    len = LEN_W'(n);
  endfunction

  function automatic logic [VAL_W-1:0] random_value();
    logic [VAL_W-1:0] v;
    case ($urandom_range(5))
      0: v = $urandom;
      1: v = VAL_W'($urandom_range(40));
      2: v = VAL_W'(0) - VAL_W'($urandom_range(40));
      3: begin
        case ($urandom_range(3))
          0:       v = 32'h8000_0000;
          1:       v = 32'h7FFF_FFFF;
          2:       v = '1;
          default: v = '0;
        endcase
      end
      default: begin
        v = $urandom >> $urandom_range(31);
        if ($urandom_range(1)) v = VAL_W'(0) - v;
      end
    endcase
    return v;
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: converts, register writes and settles from the pending queue
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin : drive
    act_t             head;
    bit               taken;
    logic             nx_start;
    logic             nx_we;
    logic [VAL_W-1:0] nx_value;
    logic [IDX_W-1:0] nx_index;
    logic [CFG_W-1:0] nx_data;
    taken    = rst_n && start && !busy;
    nx_start = 1'b0;
    nx_we    = 1'b0;
    nx_value = in_value;
    nx_index = cfg_index;
    nx_data  = cfg_wdata;
    if (!rst_n) begin
      quiet <= 0;
    end else begin
      if (taken) begin
        head = pending.pop_front();
        predict_text(head.value);
      end
      // block idle and nothing owed: count towards a safe write
      if (!busy && !start && expected_chars.size() == 0)
        quiet <= (quiet < QUIET_CYCLES) ? quiet + 1 : quiet;
      else
        quiet <= 0;
      if (start && !taken) begin
        nx_start = 1'b1;
      end else if (pending.size() != 0) begin
        head = pending[0];
        case (head.act)
          ACT_CONVERT: begin
            if ($urandom_range(99) >= head.gap_pct) begin
              nx_start = 1'b1;
              nx_value = head.value;
            end
          end
          ACT_WRITE: begin
            if (quiet >= QUIET_CYCLES) begin
              nx_we    = 1'b1;
              nx_index = head.index;
              nx_data  = head.data;
              case (head.index)
                REG_DIGITS_LOW:  alpha_lo  = head.data;
                REG_DIGITS_HIGH: alpha_hi  = head.data;
                REG_BASE_LENGTH: radix_len = head.data[LEN_W-1:0];
                default: ;
              endcase
              void'(pending.pop_front());
            end
          end
          default: begin
            if (quiet >= QUIET_CYCLES) void'(pending.pop_front());
          end
        endcase
      end
    end
    start     <= nx_start;
    in_value  <= nx_value;
    cfg_we    <= nx_we;
    cfg_index <= nx_index;
    cfg_wdata <= nx_data;
  end

  // ---------------------------------------------------------------------------
  // Monitor: every strobed character against the oldest expectation
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin : check
    text_char_t want;
    if (rst_n && out_valid) begin
      if (expected_chars.size() == 0) begin
        $error("unexpected character: char_out %h last %b", out_char_out, out_last);
        fails++;
      end else begin
        want = expected_chars.pop_front();
        if (out_char_out !== want.ch) begin
          $error("char_out: expected %h, actual %h", want.ch, out_char_out);
          fails++;
        end
        if (out_last !== want.last) begin
          $error("last: expected %b, actual %b", want.last, out_last);
          fails++;
        end
      end
    end
  end

  // Watchdog on cycles with no transaction of any kind
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid || cfg_we) begin
      stall <= 0;
    end else if (stall >= STALL_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      stall <= stall + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus and end of run
  // ---------------------------------------------------------------------------

  initial begin
    logic [CFG_W-1:0] lo, hi, base3;
    logic [LEN_W-1:0] len;
    int               sent, count;

    start     = 1'b0;
    in_value  = '0;
    cfg_we    = 1'b0;
    cfg_index = REG_DIGITS_LOW;
    cfg_wdata = '0;
    rst_n     = 1'b0;
    alpha_lo  = '0;
    alpha_hi  = '0;
    radix_len = '0;
    quiet     = 0;
    stall     = 0;
    fails     = 0;
    gap_now   = 21;

    // Alphabet after reset is empty: no output
    add_convert(32'd12345);

    // Decimal
    add_write(REG_DIGITS_LOW,  64'h3736_3534_3332_3130);
    add_write(REG_DIGITS_HIGH, 64'h4645_4443_4241_3938);
    add_write(REG_BASE_LENGTH, 64'd10);
    add_convert(32'd0);
    add_convert(32'hFFFF_FFFF);
    add_convert(32'h7FFF_FFFF);
    add_convert(32'h8000_0000);
    add_convert(-32'sd10);

    // Hexadecimal, the largest radix
    add_write(REG_BASE_LENGTH, 64'd16);
    add_convert(32'h8000_0000);
    add_convert(32'hFFFF_FFFF);
    add_convert(32'h0ABC_DEF0);

    // Binary, the smallest radix
    add_write(REG_BASE_LENGTH, 64'd2);
    add_convert(32'h8000_0000);
    add_convert(32'h7FFF_FFFF);
    add_convert(32'd0);

    // Lengths out of range
    add_write(REG_BASE_LENGTH, 64'd17);
    add_convert(32'd77);
    add_write(REG_BASE_LENGTH, 64'd31);
    add_convert(32'd77);
    add_write(REG_BASE_LENGTH, 64'd1);
    add_convert(32'd77);

    // Base 3 with extreme byte values; illegal bytes past the length are ignored
    base3 = {8'h20, 8'h09, 8'h00, 8'h2B, 8'h2D, 8'h7A, 8'h80, 8'hFF};
    add_write(REG_DIGITS_LOW, base3);
    add_write(REG_BASE_LENGTH, 64'd3);
    add_convert(32'h8000_0000);
    add_convert(32'd26);

    // Illegal byte within the length, then a repeated byte
    add_write(REG_DIGITS_LOW, {base3[63:24], CH_PLUS,  base3[15:0]});
    add_convert(32'd5);
    add_write(REG_DIGITS_LOW, {base3[63:24], CH_MINUS, base3[15:0]});
    add_convert(32'd5);
    add_write(REG_DIGITS_LOW, {base3[63:24], CH_WS_LO, base3[15:0]});
    add_convert(32'd5);
    add_write(REG_DIGITS_LOW, {base3[63:24], CH_WS_HI, base3[15:0]});
    add_convert(32'd5);
    add_write(REG_DIGITS_LOW, {base3[63:24], CH_SPACE, base3[15:0]});
    add_convert(32'd5);
    add_write(REG_DIGITS_LOW, {base3[63:24], CH_NUL,   base3[15:0]});
    add_convert(32'd5);
    add_write(REG_DIGITS_LOW, {base3[63:24], 8'hFF,    base3[15:0]});
    add_convert(32'd5);
    add_settle();

    // Random alphabets, each followed by a burst of values
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      gap_now = (sent < RANDOM_ITEMS / 3) ? 21 : (sent < 2 * RANDOM_ITEMS / 3) ? 86 : 0;
      make_alphabet(lo, hi, len);
      add_write(REG_DIGITS_LOW, lo);
      add_write(REG_DIGITS_HIGH, hi);
      add_write(REG_BASE_LENGTH, CFG_W'(len));
      count = $urandom_range(14, 4);
      repeat (count) add_convert(random_value());
      sent += count;
      if ($urandom_range(7) == 0) add_settle();
    end

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    while (pending.size() != 0 || start || busy || expected_chars.size() != 0)
      @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (fails == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule
